>>> rtl/abpg_pkg.sv
// abpg_pkg: shared types, codes and helpers for the alert buzzer pattern generator.
// No dependencies; imported by the controller, the datapath and the top level.
package abpg_pkg;

    localparam int FLAG_W = 16;
    localparam int TIME_W = 32;
    localparam int DUR_W  = 16;
    localparam int CFG_IDX_W = 3;

    // severity codes
    localparam logic [1:0] SEV_INFO = 2'd0;
    localparam logic [1:0] SEV_WARN = 2'd1;
    localparam logic [1:0] SEV_CRIT = 2'd2;
    localparam logic [1:0] SEV_CRIT_ALT = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEVERITY_MAP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_BEEP_MS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_BEEP_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_GAP_MS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_PAUSE_MS = 3'd4;

    // register reset values
    localparam logic [31:0]      RST_SEVERITY_MAP   = 32'd0;
    localparam logic [DUR_W-1:0] RST_SHORT_BEEP_MS  = 16'd120;
    localparam logic [DUR_W-1:0] RST_LONG_BEEP_MS   = 16'd600;
    localparam logic [DUR_W-1:0] RST_BEEP_GAP_MS    = 16'd150;
    localparam logic [DUR_W-1:0] RST_BURST_PAUSE_MS = 16'd2000;

    localparam logic [1:0] CRIT_BEEPS = 2'd3;
    localparam logic [1:0] WARN_BEEPS = 2'd1;

    typedef struct packed {
        logic capture;      // input transfer: latch the item
        logic eval;         // apply flag write, reduce severity
        logic update;       // advance the buzzer pattern
        logic out_load;     // load the output register
        logic out_from_next; // output from this cycle's next state
    } abpg_cmd_t;

    // code three folds onto critical
    function automatic logic [1:0] sev_fold(input logic [1:0] code);
        return (code == SEV_CRIT_ALT) ? SEV_CRIT : code;
    endfunction

    function automatic logic [1:0] beep_count(input logic [1:0] sev);
        logic [1:0] n;
        case (sev)
            SEV_CRIT: n = CRIT_BEEPS;
            SEV_WARN: n = WARN_BEEPS;
            default:  n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/abpg_ctrl.sv
// abpg_ctrl: sequencing state machine and output-register valid flag.
// Depends on abpg_pkg (command struct).
module abpg_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output abpg_pkg::abpg_cmd_t cmd
);
    import abpg_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       in_xfer;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) || ((state_reg == ST_UPD) && out_free);
    assign in_xfer  = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.capture = in_xfer;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_from_next = 1'b1;
                    state_next = in_xfer ? ST_EVAL : ST_IDLE;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_xfer_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_EVAL))
        else $error("accepted item did not enter evaluation");
    a_eval_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |=> (state_reg == ST_UPD))
        else $error("evaluation not followed by update");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output overwritten before transfer");
    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) |-> out_valid_reg)
        else $error("holding with an empty output register");

endmodule

>>> rtl/abpg_datapath.sv
// abpg_datapath: config registers, flags, severity reduction, pattern state, output register.
// Depends on abpg_pkg (codes, command struct, helpers).
module abpg_datapath #(
    parameter int ALERT_COUNT = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  abpg_pkg::abpg_cmd_t           cmd,
    input  logic                          cfg_we,
    input  logic [abpg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          mode,
    input  logic [3:0]                    alert_index,
    input  logic                          alert_active,
    input  logic [abpg_pkg::TIME_W-1:0]   now_ms,
    output logic                          buzzer_level,
    output logic [abpg_pkg::FLAG_W-1:0]   active_mask,
    output logic [1:0]                    highest_severity
);
    import abpg_pkg::*;

    // configuration
    logic [31:0]      sev_map_reg;
    logic [DUR_W-1:0] short_reg, long_reg, gap_reg, pause_reg;

    // captured item
    logic              mode_reg;
    logic [3:0]        idx_reg;
    logic              act_reg;
    logic [TIME_W-1:0] now_reg;

    // block state
    logic [FLAG_W-1:0] flags_reg, flags_next;
    logic [1:0]        target_reg, target_next;
    logic [1:0]        pat_reg, pat_next;
    logic [1:0]        beeps_reg, beeps_next;
    logic              snd_reg, snd_next;
    logic [TIME_W-1:0] pend_reg, pend_next;

    logic [TIME_W-1:0] diff;
    logic [TIME_W-1:0] phase_sum;
    logic [DUR_W-1:0]  dur;
    logic              pend_load;
    logic [1:0]        beeps_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sev_map_reg <= RST_SEVERITY_MAP;
            short_reg   <= RST_SHORT_BEEP_MS;
            long_reg    <= RST_LONG_BEEP_MS;
            gap_reg     <= RST_BEEP_GAP_MS;
            pause_reg   <= RST_BURST_PAUSE_MS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SEVERITY_MAP:   sev_map_reg <= cfg_data;
                REG_SHORT_BEEP_MS:  short_reg   <= cfg_data[DUR_W-1:0];
                REG_LONG_BEEP_MS:   long_reg    <= cfg_data[DUR_W-1:0];
                REG_BEEP_GAP_MS:    gap_reg     <= cfg_data[DUR_W-1:0];
                REG_BURST_PAUSE_MS: pause_reg   <= cfg_data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            idx_reg  <= alert_index;
            act_reg  <= alert_active;
            now_reg  <= now_ms;
        end
    end

    // evaluation: flag write, then worst severity over the new flags
    always_comb
    begin
        flags_next = flags_reg;
        if (!mode_reg && ({1'b0, idx_reg} < 5'(ALERT_COUNT)))
            flags_next[idx_reg] = act_reg;
        target_next = SEV_INFO;
        for (int i = 0; i < ALERT_COUNT; i++)
        begin
            if (flags_next[i] && (sev_fold(sev_map_reg[2*i +: 2]) > target_next))
                target_next = sev_fold(sev_map_reg[2*i +: 2]);
        end
    end

    // pattern update, tick items only
    assign diff      = now_reg - pend_reg;
    assign beeps_dec = (beeps_reg != 2'd0) ? beeps_reg - 2'd1 : 2'd0;

    always_comb
    begin
        pat_next   = pat_reg;
        beeps_next = beeps_reg;
        snd_next   = snd_reg;
        pend_next  = pend_reg;
        dur        = pause_reg;
        pend_load  = 1'b0;
        if (mode_reg)
        begin
            if (target_reg == SEV_INFO)
            begin
                snd_next   = 1'b0;
                beeps_next = 2'd0;
                pat_next   = SEV_INFO;
            end
            else if (((target_reg != pat_reg) && (beeps_reg == 2'd0) && !snd_reg)
                     || (!diff[TIME_W-1] && !snd_reg && (beeps_reg == 2'd0)))
            begin
                // new burst; target is warning or critical here, so it sounds
                pat_next   = target_reg;
                beeps_next = beep_count(target_reg);
                snd_next   = 1'b1;
                dur        = (target_reg == SEV_CRIT) ? long_reg : short_reg;
                pend_load  = 1'b1;
            end
            else if (!diff[TIME_W-1])
            begin
                if (snd_reg)
                begin
                    snd_next   = 1'b0;
                    beeps_next = beeps_dec;
                    dur        = (beeps_dec != 2'd0) ? gap_reg : pause_reg;
                    pend_load  = 1'b1;
                end
                else
                begin
                    snd_next  = 1'b1;
                    dur       = (pat_reg == SEV_CRIT) ? long_reg : short_reg;
                    pend_load = 1'b1;
                end
            end
        end
        phase_sum = now_reg + {{(TIME_W-DUR_W){1'b0}}, dur};
        if (pend_load)
            pend_next = phase_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg  <= '0;
            target_reg <= SEV_INFO;
            pat_reg    <= SEV_INFO;
            beeps_reg  <= 2'd0;
            snd_reg    <= 1'b0;
            pend_reg   <= '0;
        end
        else
        begin
            if (cmd.eval)
            begin
                flags_reg  <= flags_next;
                target_reg <= target_next;
            end
            if (cmd.update)
            begin
                pat_reg   <= pat_next;
                beeps_reg <= beeps_next;
                snd_reg   <= snd_next;
                pend_reg  <= pend_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            buzzer_level     <= cmd.out_from_next ? snd_next : snd_reg;
            active_mask      <= flags_reg;
            highest_severity <= target_reg;
        end
    end

endmodule

>>> rtl/alert_buzzer_pattern_generator.sv
// alert_buzzer_pattern_generator: top level, controller plus datapath.
// Depends on abpg_pkg, abpg_ctrl, abpg_datapath.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid in_ready mode alert_index alert_active  | into block
//          | now_ms                                           |
//  out     | out_valid out_ready buzzer_level active_mask     | out of block
//          | highest_severity                                 |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data           | into block
//
// Each item passes an evaluation state that applies a flag write and
// reduces the per-alert severities, then an update state that advances
// the buzzer pattern (time compare and phase-end add). A new item can be
// taken in the update state while the output register is free.
// If the output register is still full at the end of an update, the block
// holds the result and stops taking items until the transfer out.
// Reset puts all alert flags and pattern state to zero and the timing
// registers to their defaults; there is no clearing sweep.
// Configuration writes are always taken (cfg_ready is tied high).
module alert_buzzer_pattern_generator #(
    parameter int ALERT_COUNT = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic [3:0]                     alert_index,
    input  logic                           alert_active,
    input  logic [abpg_pkg::TIME_W-1:0]    now_ms,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           buzzer_level,
    output logic [abpg_pkg::FLAG_W-1:0]    active_mask,
    output logic [1:0]                     highest_severity,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [abpg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import abpg_pkg::*;

    abpg_cmd_t cmd;

    // writes land on the same edge as the transfer
    assign cfg_ready = 1'b1;

    abpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    abpg_datapath #(
        .ALERT_COUNT (ALERT_COUNT)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mode             (mode),
        .alert_index      (alert_index),
        .alert_active     (alert_active),
        .now_ms           (now_ms),
        .buzzer_level     (buzzer_level),
        .active_mask      (active_mask),
        .highest_severity (highest_severity)
    );

endmodule
